FILE: rtl/bmhq_pkg.sv
package bmhq_pkg;

  // Default heap depth in entries.
  localparam int unsigned CAPACITY_DEF = 128;

  localparam int unsigned TAG_W    = 16;
  localparam int unsigned PRIO_W   = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 8;

  // Operation codes.
  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  // Completion status codes.
  localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

  // One heap entry as stored in the memory.
  typedef struct packed {
    logic [PRIO_W-1:0] prio;
    logic [TAG_W-1:0]  tag;
  } slot_t;

  typedef struct packed {
    logic              operation;
    logic [TAG_W-1:0]  item_tag;
    logic [PRIO_W-1:0] priority_req;
  } in_item_t;

  typedef struct packed {
    logic [TAG_W-1:0]    out_item_tag;
    logic [PRIO_W-1:0]   out_priority;
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  entry_count;
  } out_item_t;

endpackage

FILE: rtl/bmhq_ram.sv
module bmhq_ram
  import bmhq_pkg::*;
#(
  parameter int unsigned DEPTH = CAPACITY_DEF,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  slot_t         wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output slot_t         rd_data
);

  // Heap entries; contents are undefined until written.
  slot_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: rtl/binary_min_heap_queue_core.sv
// Channel  Direction  Ports                          Transfer when
// in       input      in_valid, in_stall, in_data    in_valid high, in_stall low
// out      output     out_valid, out_stall, out_data out_valid high, out_stall low
//
// One operation is in flight; in_stall is high from its transfer until the result
// is loaded. A push or a pop moves the entry through at most log2(CAPACITY) levels
// with one memory access a cycle; a pop that empties the heap only reads the root,
// and full or empty cases go straight to the result. Reset empties the heap at once.
// A stalled result holds the output register while the next operation may already
// be accepted and worked on.
module binary_min_heap_queue_core
  import bmhq_pkg::*;
#(
  parameter int unsigned CAPACITY = CAPACITY_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  localparam int unsigned AW = $clog2(CAPACITY);
  // Count and heap positions run 0..CAPACITY.
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  typedef enum logic [9:0] {
    S_IDLE    = 10'b0000000001,
    S_UP_CHK  = 10'b0000000010,
    S_UP_CMP  = 10'b0000000100,
    S_DN_ROOT = 10'b0000001000,
    S_DN_LAST = 10'b0000010000,
    S_DN_CHK  = 10'b0000100000,
    S_DN_L    = 10'b0001000000,
    S_DN_R    = 10'b0010000000,
    S_DN_SW   = 10'b0100000000,
    S_RESP    = 10'b1000000000
  } state_t;

  state_t              state_r, state_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  logic [CW-1:0]       pos_r, pos_nxt;
  logic [CW-1:0]       pick_r, pick_nxt;
  slot_t               val_r, val_nxt;
  slot_t               cand_r, cand_nxt;
  slot_t               res_r, res_nxt;
  logic [STATUS_W-1:0] status_r, status_nxt;
  logic                out_valid_r, out_valid_nxt;
  out_item_t           out_r, out_nxt;

  // Memory port controls.
  logic                ram_wr_en;
  logic [AW-1:0]       ram_wr_addr;
  slot_t               ram_wr_data;
  logic                ram_rd_en;
  logic [AW-1:0]       ram_rd_addr;
  slot_t               ram_rd_data;

  // Child positions of the hole; one bit wider since 2*pos may pass CAPACITY.
  logic [CW:0]         lc_pos;
  logic [CW:0]         count_ext;
  logic [CW:0]         lc_m1;
  logic [CW-1:0]       parent_pos;
  logic                has_left;
  logic                has_right;

  // The one comparator, shared by sift-up and both child checks of sift-down.
  logic [PRIO_W-1:0]   cmp_a;
  logic [PRIO_W-1:0]   cmp_b;
  logic                cmp_lt;

  logic                out_free;

  bmhq_ram #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  assign lc_pos     = {pos_r, 1'b0};
  assign count_ext  = (CW + 1)'(count_r);
  assign lc_m1      = lc_pos - 1'b1;
  assign parent_pos = pos_r >> 1;
  assign has_left   = (lc_pos <= count_ext);
  // The right child exists when it is at most the count, that is lc < count.
  assign has_right  = (lc_pos < count_ext);

  // Sift-up compares the new entry with its parent; the left check compares
  // the child with the moving entry; the right check compares with the pick.
  assign cmp_a  = (state_r == S_UP_CMP) ? val_r.prio : ram_rd_data.prio;
  assign cmp_b  = (state_r == S_UP_CMP) ? ram_rd_data.prio :
                  (state_r == S_DN_L)   ? val_r.prio : cand_r.prio;
  assign cmp_lt = (cmp_a < cmp_b);

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    pos_nxt       = pos_r;
    pick_nxt      = pick_r;
    val_nxt       = val_r;
    cand_nxt      = cand_r;
    res_nxt       = res_r;
    status_nxt    = status_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;
    ram_wr_en     = 1'b0;
    ram_wr_addr   = AW'(pos_r - 1'b1);
    ram_wr_data   = val_r;
    ram_rd_en     = 1'b0;
    ram_rd_addr   = AW'(lc_m1);

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          res_nxt    = '0;
          status_nxt = STATUS_DONE;
          val_nxt    = '{prio: in_data.priority_req, tag: in_data.item_tag};
          if (in_data.operation == OP_PUSH) begin
            if ((CW + 1)'(count_r) >= (CW + 1)'(CAPACITY)) begin
              status_nxt = STATUS_FULL;
              state_nxt  = S_RESP;
            end else begin
              count_nxt = count_r + 1'b1;
              pos_nxt   = count_r + 1'b1;
              state_nxt = S_UP_CHK;
            end
          end else begin
            if (count_r == '0) begin
              status_nxt = STATUS_EMPTY;
              state_nxt  = S_RESP;
            end else begin
              ram_rd_en   = 1'b1;
              ram_rd_addr = '0;
              state_nxt   = S_DN_ROOT;
            end
          end
        end
      end

      S_UP_CHK: begin
        if (pos_r == CW'(1)) begin
          ram_wr_en = 1'b1;
          state_nxt = S_RESP;
        end else begin
          ram_rd_en   = 1'b1;
          ram_rd_addr = AW'(parent_pos - 1'b1);
          state_nxt   = S_UP_CMP;
        end
      end

      S_UP_CMP: begin
        ram_wr_en = 1'b1;
        if (cmp_lt) begin
          // Parent moves down into the hole; the hole climbs one level.
          ram_wr_data = ram_rd_data;
          pos_nxt     = parent_pos;
          state_nxt   = S_UP_CHK;
        end else begin
          state_nxt = S_RESP;
        end
      end

      S_DN_ROOT: begin
        res_nxt = ram_rd_data;
        if (count_r == CW'(1)) begin
          count_nxt = '0;
          state_nxt = S_RESP;
        end else begin
          ram_rd_en   = 1'b1;
          ram_rd_addr = AW'(count_r - 1'b1);
          count_nxt   = count_r - 1'b1;
          state_nxt   = S_DN_LAST;
        end
      end

      S_DN_LAST: begin
        val_nxt   = ram_rd_data;
        pos_nxt   = CW'(1);
        state_nxt = S_DN_CHK;
      end

      S_DN_CHK: begin
        if (has_left) begin
          ram_rd_en = 1'b1;
          state_nxt = S_DN_L;
        end else begin
          ram_wr_en = 1'b1;
          state_nxt = S_RESP;
        end
      end

      S_DN_L: begin
        if (cmp_lt) begin
          cand_nxt = ram_rd_data;
          pick_nxt = CW'(lc_pos);
        end else begin
          cand_nxt = val_r;
          pick_nxt = pos_r;
        end
        if (has_right) begin
          ram_rd_en   = 1'b1;
          ram_rd_addr = AW'(lc_pos);
          state_nxt   = S_DN_R;
        end else begin
          state_nxt = S_DN_SW;
        end
      end

      S_DN_R: begin
        if (cmp_lt) begin
          cand_nxt = ram_rd_data;
          pick_nxt = CW'(lc_pos) + 1'b1;
        end
        state_nxt = S_DN_SW;
      end

      S_DN_SW: begin
        ram_wr_en = 1'b1;
        if (pick_r == pos_r) begin
          state_nxt = S_RESP;
        end else begin
          // The chosen child moves up into the hole.
          ram_wr_data = cand_r;
          pos_nxt     = pick_r;
          state_nxt   = S_DN_CHK;
        end
      end

      S_RESP: begin
        if (out_free) begin
          out_nxt = '{out_item_tag: res_r.tag,
                      out_priority: res_r.prio,
                      status:       status_r,
                      entry_count:  COUNT_W'(count_r)};
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r    <= pos_nxt;
    pick_r   <= pick_nxt;
    val_r    <= val_nxt;
    cand_r   <= cand_nxt;
    res_r    <= res_nxt;
    status_r <= status_nxt;
    out_r    <= out_nxt;
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
